/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define BDF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define BDF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define BDF_ASSERT(label, clk, rst, prop)
`define BDF_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* hdl/bdf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bit crusher package
// Types, register indexes, reset values and the root table for the curve.
// ---------------------------------------------------------------------------
package bdf_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int MAX_HOLD    = 63;
   localparam int QBITS_MAX   = 12;
   localparam int LOG_STEPS   = 20;
   localparam int POLES       = 8;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_HOLD_PERIOD     = 3'd0,
      CSR_ACCUMULATE_MODE = 3'd1,
      CSR_QUANT_BITS      = 3'd2,
      CSR_SYMMETRIC_CURVE = 3'd3,
      CSR_CURVE_EXPONENT  = 3'd4,
      CSR_CLIP_LEVEL      = 3'd5,
      CSR_POLE_COEF       = 3'd6,
      CSR_INPUT_COEF      = 3'd7
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [5:0]  RST_HOLD_PERIOD    = 6'd1;
   localparam logic [3:0]  RST_QUANT_BITS     = 4'd6;
   localparam logic [15:0] RST_CURVE_EXPONENT = 16'd26808;
   localparam logic [23:0] RST_CLIP_LEVEL     = 24'd4204376;
   localparam logic [23:0] RST_INPUT_COEF     = 24'd1048576;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_QSET,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_EXP_MUL,
      ST_EXP_ACC,
      ST_POW_MUL,
      ST_POW_ACC,
      ST_POW_SHIFT,
      ST_CLIP,
      ST_Q_MUL,
      ST_Q_ACC,
      ST_F_MUL,
      ST_F_ACC,
      ST_X_MUL,
      ST_X_ACC,
      ST_M_LO,
      ST_M_HI,
      ST_M_SUM,
      ST_OUT
   } state_type;

   // Integer square root, evaluated at elaboration only.
   function automatic logic [63:0] isqrt_c(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] bv;
      logic [63:0] nn;
      r  = '0;
      bv = 64'd1 << 62;
      nn = n;
      for (int i = 0; i < 32; i++) begin
         if (nn >= r + bv) begin
            nn = nn - (r + bv);
            r  = (r >> 1) + bv;
         end else begin
            r = r >> 1;
         end
         bv = bv >> 2;
      end
      return r;
   endfunction

   // Factor 2^(2^-(j+1)) in Q1.30, each the floor root of the one before.
   function automatic logic [30:0] root_at(input int j);
      logic [63:0] r;
      r = isqrt_c(64'd1 << 61);
      for (int k = 1; k <= j; k++) begin
         r = isqrt_c(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

/* hdl/bdf_mul.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiply with a registered 64-bit product.
// ---------------------------------------------------------------------------
module bdf_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);

   // One product per cycle, ready on the following cycle.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

/* hdl/bitcrush_decimate_filter_top.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Bit crusher and sample rate reducer
// Stereo in, quantized and curved mono out through an eight-pole low-pass.
//
// Usage: a request carries one stereo pair on req_left_sample and
// req_right_sample and is taken when req_valid and req_ready are high.
// Every request yields exactly one rsp_degraded_sample. Settings are written
// on the csr_ channel (always ready); the user must write them only while the
// block is idle, which the block itself does not enforce. A sample that only
// runs the filter goes straight to the filter states; a sample that also
// updates the quantizer first runs a bit-serial divide, up to 15 normalize
// steps, 20 squarings and up to 20 root products, each product on the shared
// multiplier. One request is in work at a time, so a new request is taken
// only once the last one has been handed to the output register.
// Reset restores the register defaults and clears the accumulator, the held
// value and all filter poles. A finished result waits in the output register
// while the next request is taken; if the receiver still stalls when the
// next result is done, the block waits before going idle again.
// ---------------------------------------------------------------------------
module bitcrush_decimate_filter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_left_sample,
   input  logic signed [23:0] req_right_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_degraded_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);

   // Configuration registers.
   logic [5:0]  hold_period_ff;
   logic        accum_ff;
   logic [3:0]  qbits_ff;
   logic        sym_ff;
   logic [15:0] cexp_ff;
   logic [23:0] clip_ff;
   logic [23:0] pole_ff;
   logic [23:0] icoef_ff;

   // Architectural state.
   logic [31:0] acc_ff;
   logic [23:0] held_ff;
   logic [5:0]  hcount_ff;
   logic [39:0] stage_ff [bdf_pkg::POLES];

   // Sequencer and working registers.
   bdf_pkg::state_type state_ff, state_in;
   logic [4:0]  step_ff;
   logic [2:0]  j_ff;
   logic        phase_ff;
   logic        neg_ff;
   logic        pos_ff;
   logic [31:0] div_ff;
   logic [5:0]  rem_ff;
   logic [30:0] z_ff;
   logic [19:0] frac_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] e_ff;
   logic [19:0] g_ff;
   logic [4:0]  sh_ff;
   logic [30:0] r_ff;
   logic [24:0] pw_ff;
   logic [24:0] q2_ff;
   logic [24:0] fi_ff;
   logic [39:0] feed_ff;
   logic [25:0] lo_part_ff;
   logic [23:0] out_pend_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   // Shared multiplier.
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod_ff;

   bdf_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   // Root table as constant logic.
   logic [30:0] root_tab [bdf_pkg::LOG_STEPS];
   for (genvar gi = 0; gi < bdf_pkg::LOG_STEPS; gi++) begin : g_root
      localparam logic [30:0] ROOT_VAL = bdf_pkg::root_at(gi);
      assign root_tab[gi] = ROOT_VAL;
   end

   assign req_ready           = (state_ff == bdf_pkg::ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_degraded_sample = rsp_data_ff;

   // Effective period, divisor, and quantizer shift.
   logic [5:0] period;
   logic [5:0] div_n;
   logic [3:0] qb;
   logic [4:0] div_shift;
   logic [4:0] vm_shift;
   always_comb begin
      period = (hold_period_ff == 6'd0) ? 6'd1 : hold_period_ff;
      if (period > 6'(bdf_pkg::MAX_HOLD)) begin
         period = 6'(bdf_pkg::MAX_HOLD);
      end
      div_n     = accum_ff ? period : 6'd1;
      qb        = (qbits_ff > 4'(bdf_pkg::QBITS_MAX)) ? 4'(bdf_pkg::QBITS_MAX) : qbits_ff;
      div_shift = 5'd21 - {1'b0, qb};
      vm_shift  = 5'd20 - {1'b0, qb};
   end

   // Input sum with saturation to 32 bits.
   logic signed [32:0] acc_sum;
   logic [31:0]        acc_new;
   logic [31:0]        acc_mag;
   logic               fire;
   always_comb begin
      acc_sum = 33'(req_left_sample) + 33'(req_right_sample)
              + (accum_ff ? 33'(signed'(acc_ff)) : 33'sd0);
      if (acc_sum[32] != acc_sum[31]) begin
         acc_new = acc_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         acc_new = acc_sum[31:0];
      end
      acc_mag = acc_new[31] ? (~acc_new + 32'd1) : acc_new;
      fire    = (hcount_ff == period);
   end

   // Serial divide step.
   logic [6:0] rem_sh;
   logic       q_bit;
   always_comb begin
      rem_sh = {rem_ff, div_ff[31]};
      q_bit  = (rem_sh >= 7'(div_n));
   end

   // Quantized magnitude, sign and exponent choice.
   logic [63:0] vm_wide;
   logic [23:0] vm_c;
   logic        pos_c;
   logic [15:0] e_c;
   logic [15:0] e_used;
   always_comb begin
      vm_wide = 64'(div_ff) << vm_shift;
      vm_c    = (vm_wide > 64'h80_0000) ? 24'h80_0000 : vm_wide[23:0];
      pos_c   = neg_ff && (vm_c != 24'd0);
      e_c     = (cexp_ff > 16'h8000) ? 16'h8000 : cexp_ff;
      e_used  = pos_c ? (sym_ff ? e_c : 16'h8000) : e_c;
   end

   // Log and power-of-two helpers.
   logic [31:0] sq_t;
   logic [24:0] nlog;
   logic [24:0] y_val;
   logic [19:0] y_frac;
   logic [4:0]  root_idx;
   logic [31:0] pw_sum;
   logic [31:0] pw_shifted;
   always_comb begin
      sq_t       = prod_ff[61:30];
      nlog       = {cnt_ff, 20'd0} - 25'(frac_ff);
      y_val      = 25'((prod_ff[40:0] + 41'd16384) >> 15);
      y_frac     = y_val[19:0];
      root_idx   = (step_ff < 5'(bdf_pkg::LOG_STEPS)) ? step_ff : 5'd0;
      pw_sum     = {1'b0, r_ff} + (32'd1 << (sh_ff - 5'd1));
      pw_shifted = pw_sum >> sh_ff;
   end

   // Clip and sign of the held value.
   logic [23:0] clip_c;
   logic [23:0] p_cl;
   logic [23:0] held_new;
   always_comb begin
      clip_c = (clip_ff > 24'h80_0000) ? 24'h80_0000 : clip_ff;
      p_cl   = (pw_ff > {1'b0, clip_c}) ? clip_c : pw_ff[23:0];
      if (pos_ff) begin
         held_new = (p_cl == 24'h80_0000) ? 24'h7F_FFFF : p_cl;
      end else begin
         held_new = ~p_cl + 24'd1;
      end
   end

   // Filter operands and stage update.
   logic [23:0]        held_mag;
   logic [24:0]        q_val;
   logic [39:0]        v_sel;
   logic               v_neg;
   logic [39:0]        v_mag;
   logic [24:0]        c_sel;
   logic [41:0]        r_mag;
   logic signed [42:0] r_s;
   logic signed [43:0] st_sum;
   logic [39:0]        st_new;
   logic [39:0]        st_mag;
   logic [40:0]        o_rnd;
   logic [32:0]        o_mag;
   logic [23:0]        o_val;
   always_comb begin
      held_mag = held_ff[23] ? (~held_ff + 24'd1) : held_ff;
      q_val    = 25'h100_0000 - {1'b0, pole_ff};
      v_sel    = phase_ff ? stage_ff[j_ff] : feed_ff;
      v_neg    = v_sel[39];
      v_mag    = v_neg ? (~v_sel + 40'd1) : v_sel;
      c_sel    = phase_ff ? {1'b0, pole_ff} : fi_ff;
      r_mag    = prod_ff[41:0] + 42'(lo_part_ff);
      r_s      = v_neg ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});
      st_sum   = 44'(signed'(feed_ff)) + 44'(r_s);
      if (st_sum[43:39] != {5{st_sum[43]}}) begin
         st_new = st_sum[43] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
      end else begin
         st_new = st_sum[39:0];
      end
      st_mag = st_new[39] ? (~st_new + 40'd1) : st_new;
      o_rnd  = 41'(st_mag) + 41'd128;
      o_mag  = o_rnd[40:8];
      if (!st_new[39]) begin
         o_val = (o_mag > 33'h7F_FFFF) ? 24'h7F_FFFF : o_mag[23:0];
      end else begin
         o_val = (o_mag > 33'h80_0000) ? 24'h80_0000 : (~o_mag[23:0] + 24'd1);
      end
   end

   // Next state and multiplier operands.
   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         bdf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fire ? bdf_pkg::ST_DIV : bdf_pkg::ST_Q_MUL;
            end
         end
         bdf_pkg::ST_DIV: begin
            if (step_ff == 5'd31) begin
               state_in = bdf_pkg::ST_QSET;
            end
         end
         bdf_pkg::ST_QSET: begin
            if (vm_c == 24'd0 || e_used >= 16'h8000) begin
               state_in = bdf_pkg::ST_CLIP;
            end else begin
               state_in = bdf_pkg::ST_NORM;
            end
         end
         bdf_pkg::ST_NORM: begin
            if (z_ff[30]) begin
               state_in = bdf_pkg::ST_SQ_MUL;
            end
         end
         bdf_pkg::ST_SQ_MUL: begin
            mul_a    = 32'(z_ff);
            mul_b    = 32'(z_ff);
            state_in = bdf_pkg::ST_SQ_ACC;
         end
         bdf_pkg::ST_SQ_ACC: begin
            state_in = (step_ff == 5'(bdf_pkg::LOG_STEPS - 1)) ?
                       bdf_pkg::ST_EXP_MUL : bdf_pkg::ST_SQ_MUL;
         end
         bdf_pkg::ST_EXP_MUL: begin
            mul_a    = 32'(nlog);
            mul_b    = 32'(e_ff);
            state_in = bdf_pkg::ST_EXP_ACC;
         end
         bdf_pkg::ST_EXP_ACC: begin
            state_in = bdf_pkg::ST_POW_MUL;
         end
         bdf_pkg::ST_POW_MUL: begin
            mul_a = 32'(r_ff);
            mul_b = 32'(root_tab[root_idx]);
            if (step_ff == 5'(bdf_pkg::LOG_STEPS)) begin
               state_in = bdf_pkg::ST_POW_SHIFT;
            end else if (g_ff[19]) begin
               state_in = bdf_pkg::ST_POW_ACC;
            end
         end
         bdf_pkg::ST_POW_ACC: begin
            state_in = bdf_pkg::ST_POW_MUL;
         end
         bdf_pkg::ST_POW_SHIFT: begin
            state_in = bdf_pkg::ST_CLIP;
         end
         bdf_pkg::ST_CLIP: begin
            state_in = bdf_pkg::ST_Q_MUL;
         end
         bdf_pkg::ST_Q_MUL: begin
            mul_a    = 32'(q_val);
            mul_b    = 32'(q_val);
            state_in = bdf_pkg::ST_Q_ACC;
         end
         bdf_pkg::ST_Q_ACC: begin
            state_in = bdf_pkg::ST_F_MUL;
         end
         bdf_pkg::ST_F_MUL: begin
            mul_a    = 32'(q2_ff);
            mul_b    = 32'(q2_ff);
            state_in = bdf_pkg::ST_F_ACC;
         end
         bdf_pkg::ST_F_ACC: begin
            state_in = bdf_pkg::ST_X_MUL;
         end
         bdf_pkg::ST_X_MUL: begin
            mul_a    = 32'(held_mag);
            mul_b    = 32'(icoef_ff);
            state_in = bdf_pkg::ST_X_ACC;
         end
         bdf_pkg::ST_X_ACC: begin
            state_in = bdf_pkg::ST_M_LO;
         end
         bdf_pkg::ST_M_LO: begin
            mul_a    = 32'(v_mag[23:0]);
            mul_b    = 32'(c_sel);
            state_in = bdf_pkg::ST_M_HI;
         end
         bdf_pkg::ST_M_HI: begin
            mul_a    = 32'(v_mag[39:24]);
            mul_b    = 32'(c_sel);
            state_in = bdf_pkg::ST_M_SUM;
         end
         bdf_pkg::ST_M_SUM: begin
            if (phase_ff && j_ff == 3'(bdf_pkg::POLES - 1)) begin
               state_in = bdf_pkg::ST_OUT;
            end else begin
               state_in = bdf_pkg::ST_M_LO;
            end
         end
         bdf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdf_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration, architectural state and result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_period_ff <= bdf_pkg::RST_HOLD_PERIOD;
         accum_ff       <= 1'b0;
         qbits_ff       <= bdf_pkg::RST_QUANT_BITS;
         sym_ff         <= 1'b1;
         cexp_ff        <= bdf_pkg::RST_CURVE_EXPONENT;
         clip_ff        <= bdf_pkg::RST_CLIP_LEVEL;
         pole_ff        <= '0;
         icoef_ff       <= bdf_pkg::RST_INPUT_COEF;
         acc_ff         <= '0;
         held_ff        <= '0;
         hcount_ff      <= 6'd1;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < bdf_pkg::POLES; i++) begin
            stage_ff[i] <= '0;
         end
      end else begin
         // Register writes; a write restarts the hold count unless a request is taken in the same cycle.
         if (csr_valid) begin
            unique case (bdf_pkg::csr_index_type'(csr_index))
               bdf_pkg::CSR_HOLD_PERIOD:     hold_period_ff <= csr_data[5:0];
               bdf_pkg::CSR_ACCUMULATE_MODE: accum_ff       <= csr_data[0];
               bdf_pkg::CSR_QUANT_BITS:      qbits_ff       <= csr_data[3:0];
               bdf_pkg::CSR_SYMMETRIC_CURVE: sym_ff         <= csr_data[0];
               bdf_pkg::CSR_CURVE_EXPONENT:  cexp_ff        <= csr_data[15:0];
               bdf_pkg::CSR_CLIP_LEVEL:      clip_ff        <= csr_data;
               bdf_pkg::CSR_POLE_COEF:       pole_ff        <= csr_data;
               bdf_pkg::CSR_INPUT_COEF:      icoef_ff       <= csr_data;
            endcase
         end
         // Accumulator and hold counter on each request.
         if (req_valid && req_ready) begin
            acc_ff    <= fire ? 32'd0 : acc_new;
            hcount_ff <= fire ? 6'd1 : (hcount_ff + 6'd1);
         end else if (csr_valid) begin
            hcount_ff <= 6'd1;
         end
         // New held value after the curve and clip.
         if (state_ff == bdf_pkg::ST_CLIP) begin
            held_ff <= held_new;
         end
         // Filter pole write-back.
         if (state_ff == bdf_pkg::ST_M_SUM && phase_ff) begin
            stage_ff[j_ff] <= st_new;
         end
         // Output register.
         if (state_ff == bdf_pkg::ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         bdf_pkg::ST_IDLE: begin
            neg_ff  <= acc_new[31];
            div_ff  <= acc_mag >> div_shift;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         bdf_pkg::ST_DIV: begin
            rem_ff  <= q_bit ? 6'(rem_sh - 7'(div_n)) : rem_sh[5:0];
            div_ff  <= {div_ff[30:0], q_bit};
            step_ff <= step_ff + 5'd1;
         end
         bdf_pkg::ST_QSET: begin
            pos_ff  <= pos_c;
            e_ff    <= e_used;
            pw_ff   <= (e_used >= 16'h8000) ? 25'(vm_c) : 25'd0;
            z_ff    <= {vm_c, 7'd0};
            cnt_ff  <= '0;
            frac_ff <= '0;
            step_ff <= '0;
         end
         bdf_pkg::ST_NORM: begin
            if (!z_ff[30]) begin
               z_ff   <= {z_ff[29:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         bdf_pkg::ST_SQ_ACC: begin
            frac_ff <= {frac_ff[18:0], sq_t[31]};
            z_ff    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
            step_ff <= step_ff + 5'd1;
         end
         bdf_pkg::ST_EXP_ACC: begin
            g_ff    <= (y_frac != 20'd0) ? (20'd0 - y_frac) : 20'd0;
            sh_ff   <= y_val[24:20] + 5'd7 + {4'd0, (y_frac != 20'd0)};
            r_ff    <= 31'h4000_0000;
            step_ff <= '0;
         end
         bdf_pkg::ST_POW_MUL: begin
            if (step_ff != 5'(bdf_pkg::LOG_STEPS) && !g_ff[19]) begin
               g_ff    <= {g_ff[18:0], 1'b0};
               step_ff <= step_ff + 5'd1;
            end
         end
         bdf_pkg::ST_POW_ACC: begin
            r_ff    <= prod_ff[60:30];
            g_ff    <= {g_ff[18:0], 1'b0};
            step_ff <= step_ff + 5'd1;
         end
         bdf_pkg::ST_POW_SHIFT: begin
            pw_ff <= pw_shifted[24:0];
         end
         bdf_pkg::ST_Q_ACC: begin
            q2_ff <= 25'((prod_ff[49:0] + 50'h80_0000) >> 24);
         end
         bdf_pkg::ST_F_ACC: begin
            fi_ff <= 25'((prod_ff[49:0] + 50'h80_0000) >> 24);
         end
         bdf_pkg::ST_X_ACC: begin
            // First pole input: held times gain, rounded to Q8.31.
            feed_ff <= held_ff[23] ?
                       (40'd0 - 40'((prod_ff[47:0] + 48'd2048) >> 12)) :
                       40'((prod_ff[47:0] + 48'd2048) >> 12);
            j_ff     <= '0;
            phase_ff <= 1'b0;
         end
         bdf_pkg::ST_M_HI: begin
            lo_part_ff <= 26'(prod_ff[49:24]) + 26'(prod_ff[23]);
         end
         bdf_pkg::ST_M_SUM: begin
            if (!phase_ff) begin
               feed_ff  <= r_s[39:0];
               phase_ff <= 1'b1;
            end else begin
               feed_ff     <= st_new;
               out_pend_ff <= o_val;
               j_ff        <= j_ff + 3'd1;
               phase_ff    <= (j_ff + 3'd1 != 3'd4);
            end
         end
         bdf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_ff <= out_pend_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Checks on the sequencer and datapath.
   `BDF_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `BDF_ASSERT(a_div_rem, clock, reset, (state_ff == bdf_pkg::ST_DIV) |-> (rem_ff < div_n))
   `BDF_ASSERT(a_norm_sq, clock, reset, (state_ff == bdf_pkg::ST_SQ_MUL) |-> z_ff[30])
   `BDF_ASSERT(a_shift_range, clock, reset, (state_ff == bdf_pkg::ST_POW_SHIFT) |-> (sh_ff >= 5'd7))
   `BDF_ASSERT_NEVER(a_pow_step, clock, reset, (state_ff == bdf_pkg::ST_POW_MUL) && (step_ff > 5'd20))

endmodule
